// File: src/mdpme_pkg.sv
// Package: types and constants for the MDP model estimator.
package mdpme_pkg;

	localparam int NUM_STATES  = 16;
	localparam int NUM_ACTIONS = 4;
	localparam int SW          = $clog2(NUM_STATES);
	localparam int AW          = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
	localparam int NXW         = $clog2(NUM_STATES + 1);
	localparam int PAIRS       = NUM_STATES * NUM_ACTIONS;
	localparam int PW          = $clog2(PAIRS);
	localparam int TRANS       = PAIRS * (NUM_STATES + 1);
	localparam int TW          = $clog2(TRANS);

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [0:0] REG_HORIZON  = 1'b0;
	localparam logic [0:0] REG_FALLBACK = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [3:0]         state;
		logic [1:0]         action;
		logic [4:0]         next_state;
		logic signed [15:0] reward;
		logic               trajectory_end;
	} in_item_t;

	typedef struct packed {
		logic [16:0]        probability;
		logic signed [15:0] mean_reward;
		logic [16:0]        start_probability;
		logic               status;
	} out_item_t;

	// divider request: round(num/den), halves rounded up, 48-bit numerator
	typedef struct packed {
		logic        start;
		logic [47:0] num;
		logic [15:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [32:0] quo;
	} div_rsp_t;

endpackage

// File: src/mdpme_div.sv
// Iterative restoring divider, one quotient bit per cycle, rounds to nearest.
module mdpme_div import mdpme_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	// computes (num + den/2) / den
	logic [48:0] rem_q;
	logic [48:0] quo_q;
	logic [15:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [49:0] trial;

	assign trial = {rem_q[48:0], quo_q[48]} - {34'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd49;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= {1'b0, req.num} + {34'd0, req.den[15:1]};
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[49]) begin
				rem_q <= trial[48:0];
				quo_q <= {quo_q[47:0], 1'b1};
			end else begin
				rem_q <= {rem_q[47:0], quo_q[48]};
				quo_q <= {quo_q[47:0], 1'b0};
			end
		end
	end

	assign rsp = {done_q, quo_q[32:0]};
endmodule

// File: src/mdp_model_estimator_core.sv
// Top level: tabular MDP maximum-likelihood model estimator.
//
// Usage
//  - Input channel (in_valid/in_ready, payload in_item): one transaction is
//    either a sample to fold into the model (cmd 0) or a query (cmd 1).
//  - Output channel (out_valid/out_ready, payload out_item): one result per
//    input transaction, in order. Samples give status only; queries give
//    transition probability, mean reward and start probability.
//  - Config port (cfg_we/cfg_idx/cfg_wdata): register 0 horizon, 1 fallback
//    mode. Write only while idle.
//  - One item at a time. A sample shows its result when the read, modify
//    and write back of the counter memories are done; the next transaction
//    is taken after the output handshake. A query shows its result after
//    three divisions in turn through the shared bit-serial divider, each a
//    start, the quotient bits in turn and a hand-back of the quotient; the
//    next transaction is taken after its output handshake. A query with no
//    trajectories seen skips the divisions.
//  - Reset: a clearing pass sweeps the 1088-entry transition memory (and
//    the smaller tables with it) one entry per cycle, with in_ready low.
//    Config writes are taken during it.
//  - Receiver stall: the result sits in the output register; in_ready stays
//    low until it is taken.
module mdp_model_estimator_core import mdpme_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item,
	input  logic       cfg_we,
	input  logic [0:0] cfg_idx,
	input  logic [7:0] cfg_wdata
);
	typedef enum logic [10:0] {
		ST_CLR  = 11'b00000000001,
		ST_IDLE = 11'b00000000010,
		ST_RD   = 11'b00000000100,
		ST_MOD  = 11'b00000001000,
		ST_WR   = 11'b00000010000,
		ST_D1   = 11'b00000100000,
		ST_W1   = 11'b00001000000,
		ST_D2   = 11'b00010000000,
		ST_W2   = 11'b00100000000,
		ST_D3   = 11'b01000000000,
		ST_OUT  = 11'b10000000000
	} state_t;

	state_t st_q;

	// memories
	logic [63:0] tmem [TRANS];   // {tc, tca, reward_total}
	logic [31:0] pmem [PAIRS];   // {pc, pca}
	logic [15:0] smem [NUM_STATES];
	logic [63:0] trd_q;
	logic [31:0] prd_q;
	logic [15:0] srd_q;

	logic [TW:0] clr_q;
	logic [7:0]  horizon_q;
	logic        fb_q;
	logic [15:0] traj_q;
	logic [7:0]  step_q;
	logic signed [15:0] low_q;
	logic        lowv_q;
	in_item_t    it_q;
	logic [NXW-1:0] nx_q;
	logic        ok_q;
	logic [16:0] prob_q;
	logic signed [15:0] mean_q;
	logic        neg_q;
	div_req_t    dreq;
	div_rsp_t    drsp;

	mdpme_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [NXW-1:0] nx_in;
	assign nx_in = (in_item.next_state > 5'(NUM_STATES) || (in_item.cmd == CMD_ADD
		&& in_item.trajectory_end)) ? NXW'(NUM_STATES) : NXW'(in_item.next_state);

	logic [PW-1:0] pa;
	logic [TW-1:0] ta;
	assign pa = {it_q.state, it_q.action};
	assign ta = TW'(pa) * TW'(NUM_STATES + 1) + TW'(nx_q);

	assign in_ready = (st_q == ST_IDLE);

	// fields of read words
	logic [15:0] tc, tca, pc, pca;
	logic signed [31:0] rt;
	assign tc  = trd_q[63:48];
	assign tca = trd_q[47:32];
	assign rt  = trd_q[31:0];
	assign pc  = prd_q[31:16];
	assign pca = prd_q[15:0];

	function automatic logic [15:0] sinc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	logic hstep, term, first;
	assign hstep = (horizon_q != 8'd0) && (step_q == horizon_q - 8'd1);
	assign term  = (nx_q == NXW'(NUM_STATES));
	assign first = (step_q == 8'd0);

	logic [31:0] mag;
	assign mag = rt[31] ? 32'(-rt) : 32'(rt);

	always_ff @(posedge clk) begin
		if (st_q == ST_CLR) begin
			tmem[clr_q[TW-1:0]] <= '0;
			pmem[clr_q[PW-1:0]] <= '0;
			smem[clr_q[SW-1:0]] <= '0;
		end else if (st_q == ST_WR && ok_q && it_q.cmd == CMD_ADD) begin
			tmem[ta] <= {hstep ? tc : sinc(tc), sinc(tca),
				(tca == 16'hFFFF) ? rt : rt + 32'(it_q.reward)};
			pmem[pa] <= {hstep ? pc : sinc(pc), sinc(pca)};
			if (first) smem[it_q.state] <= sinc(srd_q);
		end
		if (st_q == ST_RD) begin
			trd_q <= tmem[ta];
			prd_q <= pmem[pa];
			srd_q <= smem[it_q.state];
		end
	end

	always_comb begin
		dreq = '0;
		unique case (st_q)
			ST_D1: begin
				dreq.start = 1'b1;
				dreq.num = {16'd0, tc, 16'd0};
				dreq.den = pc;
			end
			ST_D2: begin
				dreq.start = 1'b1;
				dreq.num = 48'(mag);
				dreq.den = tca;
			end
			ST_D3: begin
				dreq.start = 1'b1;
				dreq.num = {16'd0, srd_q, 16'd0};
				dreq.den = traj_q;
			end
			default: dreq = '0;
		endcase
	end

	function automatic logic [16:0] clip(input logic [32:0] q);
		return (q > 33'd65536) ? 17'd65536 : q[16:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			horizon_q <= 8'd16;
			fb_q <= 1'b0;
			traj_q <= '0;
			step_q <= '0;
			low_q <= '0;
			lowv_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_HORIZON:  horizon_q <= cfg_wdata;
					REG_FALLBACK: fb_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (TW+1)'(TRANS - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (in_valid) begin
					it_q <= in_item;
					nx_q <= nx_in;
					ok_q <= 1'b1;
					st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_MOD;
				ST_MOD: begin
					if (it_q.cmd == CMD_ADD) begin
						st_q <= ST_WR;
						out_item <= '{probability: 17'd0, mean_reward: 16'sd0,
							start_probability: 17'd0, status: hstep && !term};
					end else begin
						out_item <= '0;
						if (traj_q == 16'd0) begin
							st_q <= ST_OUT;
							out_valid <= 1'b1;
						end else st_q <= ST_D1;
					end
				end
				ST_WR: begin
					if (first) traj_q <= sinc(traj_q);
					if (!lowv_q || it_q.reward < low_q) begin
						low_q <= it_q.reward;
						lowv_q <= 1'b1;
					end
					if (term) step_q <= '0;
					else if (step_q != 8'hFF) step_q <= step_q + 8'd1;
					st_q <= ST_OUT;
					out_valid <= 1'b1;
				end
				ST_D1: st_q <= ST_W1;
				ST_W1: if (drsp.done) begin
					if (pc == 16'd0)
						prob_q <= (nx_q == (fb_q ? NXW'(it_q.state) : NXW'(NUM_STATES)))
							? 17'd65536 : 17'd0;
					else prob_q <= clip(drsp.quo);
					st_q <= ST_D2;
				end
				ST_D2: begin
					neg_q <= rt[31];
					st_q <= ST_W2;
				end
				ST_W2: if (drsp.done) begin
					if (tca == 16'd0) mean_q <= (fb_q && lowv_q) ? low_q : 16'sd0;
					else mean_q <= neg_q ? -16'(drsp.quo) : 16'(drsp.quo);
					st_q <= ST_D3;
				end
				ST_D3: st_q <= ST_OUT;
				ST_OUT: begin
					if (it_q.cmd == CMD_QUERY && traj_q != 16'd0 && drsp.done) begin
						out_item <= '{probability: prob_q, mean_reward: mean_q,
							start_probability: clip(drsp.quo), status: 1'b0};
						out_valid <= 1'b1;
					end else if (out_valid && out_ready) begin
						out_valid <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// assertions
	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("accept while busy");
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready with result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLR) |-> !out_valid) else $error("output during clear");
endmodule
